/* hdl/frt_pkg.sv */
// ----------------------------------------------------------------------------
// frt_pkg: shared types and constants of the fragment reassembly tracker
// Slot geometry, field widths, command and status codes, and the summary
// that the slot scanner hands to the sequencer.
// ----------------------------------------------------------------------------
package frt_pkg;

    // table geometry
    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int VCNT_W = $clog2(SLOTS + 1);

    // field widths
    localparam int ID_W   = 32;
    localparam int IDX_W  = 5;
    localparam int FCNT_W = 6;
    localparam int MAP_W  = 1 << IDX_W;
    localparam int ST_W   = 3;

    // command codes
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_POP = 1'b1;

    // status codes
    localparam logic [ST_W-1:0] ST_PENDING   = 3'd0;
    localparam logic [ST_W-1:0] ST_ALREADY   = 3'd1;
    localparam logic [ST_W-1:0] ST_BADINDEX  = 3'd2;
    localparam logic [ST_W-1:0] ST_COMPLETED = 3'd3;
    localparam logic [ST_W-1:0] ST_POPPED    = 3'd4;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd5;

    // summary of one pass over a table
    typedef struct packed {
        logic              match_found;
        logic [SLOT_W-1:0] match_slot;
        logic              free_found;
        logic [SLOT_W-1:0] free_slot;
        logic              min_found;
        logic [SLOT_W-1:0] min_slot;
        logic [ID_W-1:0]   min_id;
        logic [VCNT_W-1:0] valid_cnt;
    } scan_t;

endpackage

/* hdl/frt_slot_scan.sv */
// ----------------------------------------------------------------------------
// frt_slot_scan: one-slot-per-cycle table scanner
// Walks a table one slot per step cycle with a single equality and a single
// less-than compare, and keeps the first matching slot, the first free slot,
// the slot of the smallest valid id and the number of valid slots.
// ----------------------------------------------------------------------------
module frt_slot_scan (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic                      step,
    input  logic [frt_pkg::SLOT_W-1:0] slot,
    input  logic                      entry_valid,
    input  logic [frt_pkg::ID_W-1:0]  entry_id,
    input  logic [frt_pkg::ID_W-1:0]  key,
    output logic                      hit,
    output frt_pkg::scan_t            summary
);
    import frt_pkg::*;

    scan_t acc_reg;
    scan_t acc_next;
    logic  id_eq;
    logic  id_lt;

    // the shared compare unit
    assign id_eq = (entry_id == key);
    assign id_lt = (entry_id < acc_reg.min_id);

    // first matching slot of this pass
    assign hit = step && entry_valid && id_eq && !acc_reg.match_found;

    // fold the current slot into the running summary
    always_comb
    begin
        acc_next = acc_reg;
        if (clear)
        begin
            acc_next.match_found = 1'b0;
            acc_next.free_found  = 1'b0;
            acc_next.min_found   = 1'b0;
            acc_next.valid_cnt   = '0;
        end
        else if (step)
        begin
            if (hit)
            begin
                acc_next.match_found = 1'b1;
                acc_next.match_slot  = slot;
            end
            if (!entry_valid && !acc_reg.free_found)
            begin
                acc_next.free_found = 1'b1;
                acc_next.free_slot  = slot;
            end
            if (entry_valid && (!acc_reg.min_found || id_lt))
            begin
                acc_next.min_found = 1'b1;
                acc_next.min_slot  = slot;
                acc_next.min_id    = entry_id;
            end
            if (entry_valid)
            begin
                acc_next.valid_cnt = acc_reg.valid_cnt + VCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg.match_found <= 1'b0;
            acc_reg.match_slot  <= '0;
            acc_reg.free_found  <= 1'b0;
            acc_reg.free_slot   <= '0;
            acc_reg.min_found   <= 1'b0;
            acc_reg.min_slot    <= '0;
            acc_reg.min_id      <= '0;
            acc_reg.valid_cnt   <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign summary = acc_reg;

    // a matching slot is a valid slot, so a minimum exists
    a_match_has_min: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg.match_found |-> acc_reg.min_found)
        else $error("scan found a match without a valid minimum");

    // never count more valid slots than the table has
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg.valid_cnt <= VCNT_W'(SLOTS))
        else $error("scan valid count exceeds table size");

    // a new pass starts from an empty summary
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (acc_reg.valid_cnt == '0 && !acc_reg.min_found
                   && !acc_reg.match_found && !acc_reg.free_found))
        else $error("scan summary not cleared");

endmodule

/* hdl/fragment_reassembly_tracker.sv */
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker: fragment arrival and completion tracker
// Keeps a 16-slot pending table with per-frame arrival bitmaps and a 16-slot
// completed queue ordered by frame id; answers add and pop commands.
// ----------------------------------------------------------------------------
// Each accepted command word goes through a scan state, in which a pair of
// slot scanners walk the pending table and the completed queue one slot per
// cycle (matching id, first free slot, smallest id, valid count), and then a
// finish state that applies the update and loads the result register; the
// result word is valid once that finish step commits.
// cmd_stall is high for the whole scan and finish; a new word is taken once
// the previous one has committed, and the result register holds its word
// until the consumer takes it, so a stalled consumer holds the finish step
// only. All tables reset to empty at once, with no clearing pass.
module fragment_reassembly_tracker #(
    parameter int PENDING_LIMIT   = 15,
    parameter int COMPLETED_LIMIT = 15,
    parameter int MAX_FRAGMENTS   = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // command channel
    input  logic                       cmd_valid,
    output logic                       cmd_stall,
    input  logic                       command,
    input  logic [frt_pkg::ID_W-1:0]   frame_id,
    input  logic [frt_pkg::IDX_W-1:0]  fragment_index,
    input  logic [frt_pkg::FCNT_W-1:0] fragment_count,
    // response channel
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic [frt_pkg::ST_W-1:0]   status,
    output logic [frt_pkg::ID_W-1:0]   result_frame_id,
    output logic                       gap_detected,
    output logic                       pending_dropped,
    output logic [frt_pkg::ID_W-1:0]   pending_dropped_id,
    output logic                       completed_dropped,
    output logic [frt_pkg::ID_W-1:0]   completed_dropped_id
);
    import frt_pkg::*;

    localparam logic [FCNT_W:0] MAX_FRAG = (FCNT_W + 1)'(MAX_FRAGMENTS);
    localparam logic [6:0]      PEND_LIM = 7'(PENDING_LIMIT);
    localparam logic [6:0]      COMP_LIM = 7'(COMPLETED_LIMIT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // tables
    logic [SLOTS-1:0]  pending_valid_reg;
    logic [SLOTS-1:0]  pending_valid_next;
    logic [ID_W-1:0]   pending_id_reg    [SLOTS];
    logic [FCNT_W-1:0] pending_count_reg [SLOTS];
    logic [MAP_W-1:0]  pending_map_reg   [SLOTS];
    logic [SLOTS-1:0]  completed_valid_reg;
    logic [SLOTS-1:0]  completed_valid_next;
    logic [ID_W-1:0]   completed_id_reg  [SLOTS];
    logic [ID_W-1:0]   last_completed_reg;
    logic [ID_W-1:0]   last_completed_next;

    // captured command word
    logic              cmd_reg;
    logic [ID_W-1:0]   fid_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [FCNT_W-1:0] cnt_reg;

    // sequencer
    logic [SLOT_W-1:0] scan_idx_reg;
    logic [FCNT_W-1:0] match_count_reg;
    logic [MAP_W-1:0]  match_map_reg;

    // result register
    logic              rsp_valid_reg;
    logic [ST_W-1:0]   status_reg;
    logic [ST_W-1:0]   status_next;
    logic [ID_W-1:0]   rid_reg;
    logic [ID_W-1:0]   rid_next;
    logic              gap_reg;
    logic              gap_next;
    logic              pdrop_reg;
    logic              pdrop_next;
    logic [ID_W-1:0]   pdid_reg;
    logic [ID_W-1:0]   pdid_next;
    logic              cdrop_reg;
    logic              cdrop_next;
    logic [ID_W-1:0]   cdid_reg;
    logic [ID_W-1:0]   cdid_next;

    // scanners
    logic              cmd_take;
    logic              scan_step;
    logic              p_hit;
    logic              c_hit;
    scan_t             p_sum;
    scan_t             c_sum;

    // table writes from the finish step
    logic              commit;
    logic              p_wr_en;
    logic              p_wr_new;
    logic [SLOT_W-1:0] p_wr_slot;
    logic [MAP_W-1:0]  p_wr_map;
    logic              c_wr_en;
    logic [SLOT_W-1:0] c_wr_slot;

    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign scan_step = (state_reg == S_SCAN);
    assign commit    = (state_reg == S_FINISH) && (!rsp_valid_reg || !rsp_stall);

    frt_slot_scan u_pend_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (cmd_take),
        .step        (scan_step),
        .slot        (scan_idx_reg),
        .entry_valid (pending_valid_reg[scan_idx_reg]),
        .entry_id    (pending_id_reg[scan_idx_reg]),
        .key         (fid_reg),
        .hit         (p_hit),
        .summary     (p_sum)
    );

    frt_slot_scan u_comp_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (cmd_take),
        .step        (scan_step),
        .slot        (scan_idx_reg),
        .entry_valid (completed_valid_reg[scan_idx_reg]),
        .entry_id    (completed_id_reg[scan_idx_reg]),
        .key         (fid_reg),
        .hit         (c_hit),
        .summary     (c_sum)
    );

    // advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_idx_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // apply the command once both tables are summarized
    always_comb
    begin
        logic [FCNT_W-1:0] eff_count;
        logic [MAP_W-1:0]  eff_map;
        logic [MAP_W-1:0]  bit_mask;
        logic [MAP_W-1:0]  new_map;
        logic [MAP_W-1:0]  full_mask;
        logic              bad;
        logic              complete;

        pending_valid_next   = pending_valid_reg;
        completed_valid_next = completed_valid_reg;
        last_completed_next  = last_completed_reg;
        status_next          = ST_PENDING;
        rid_next             = '0;
        gap_next             = 1'b0;
        pdrop_next           = 1'b0;
        pdid_next            = '0;
        cdrop_next           = 1'b0;
        cdid_next            = '0;
        p_wr_en              = 1'b0;
        p_wr_new             = !p_sum.match_found;
        c_wr_en              = 1'b0;
        c_wr_slot            = c_sum.free_found ? c_sum.free_slot : c_sum.min_slot;

        // pick the entry this fragment belongs to
        if (p_sum.match_found)
        begin
            eff_count = match_count_reg;
            eff_map   = match_map_reg;
            p_wr_slot = p_sum.match_slot;
            bad       = ({1'b0, idx_reg} >= eff_count);
        end
        else
        begin
            eff_count = cnt_reg;
            eff_map   = '0;
            p_wr_slot = p_sum.free_found ? p_sum.free_slot : p_sum.min_slot;
            bad       = (cnt_reg == '0) || ({1'b0, cnt_reg} > MAX_FRAG)
                        || ({1'b0, idx_reg} >= cnt_reg);
        end

        bit_mask  = MAP_W'(1) << idx_reg;
        new_map   = eff_map | bit_mask;
        full_mask = (eff_count >= FCNT_W'(MAP_W)) ? '1
                    : ((MAP_W'(1) << eff_count[IDX_W-1:0]) - MAP_W'(1));
        complete  = (eff_count <= FCNT_W'(MAP_W)) && ((new_map & full_mask) == full_mask);
        p_wr_map  = new_map;

        if (cmd_reg == CMD_POP)
        begin
            if (!c_sum.min_found)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                status_next         = ST_POPPED;
                rid_next            = c_sum.min_id;
                gap_next            = (c_sum.min_id != (last_completed_reg + ID_W'(1)));
                last_completed_next = c_sum.min_id;
                completed_valid_next[c_sum.min_slot] = 1'b0;
            end
        end
        else if (fid_reg <= last_completed_reg)
        begin
            status_next = ST_ALREADY;
        end
        else if (bad)
        begin
            status_next = ST_BADINDEX;
        end
        else if ((eff_map & bit_mask) != '0)
        begin
            status_next = ST_ALREADY;
        end
        else
        begin
            p_wr_en = 1'b1;

            // store a new pending entry, evicting the smallest id over the limit
            if (p_wr_new)
            begin
                pending_valid_next[p_wr_slot] = 1'b1;
                if (!p_sum.free_found)
                begin
                    pdrop_next = 1'b1;
                    pdid_next  = p_sum.min_id;
                end
                else if ((7'(p_sum.valid_cnt) + 7'd1) > PEND_LIM)
                begin
                    pdrop_next = 1'b1;
                    if (!p_sum.min_found || (fid_reg < p_sum.min_id))
                    begin
                        pending_valid_next[p_wr_slot] = 1'b0;
                        pdid_next = fid_reg;
                    end
                    else
                    begin
                        pending_valid_next[p_sum.min_slot] = 1'b0;
                        pdid_next = p_sum.min_id;
                    end
                end
            end

            if (complete)
            begin
                status_next = ST_COMPLETED;
                rid_next    = fid_reg;
                // queue the frame unless it is queued already
                if (!c_sum.match_found)
                begin
                    c_wr_en = 1'b1;
                    completed_valid_next[c_wr_slot] = 1'b1;
                    if (!c_sum.free_found)
                    begin
                        cdrop_next = 1'b1;
                        cdid_next  = c_sum.min_id;
                    end
                    else if ((7'(c_sum.valid_cnt) + 7'd1) > COMP_LIM)
                    begin
                        cdrop_next = 1'b1;
                        if (!c_sum.min_found || (fid_reg < c_sum.min_id))
                        begin
                            completed_valid_next[c_wr_slot] = 1'b0;
                            cdid_next = fid_reg;
                        end
                        else
                        begin
                            completed_valid_next[c_sum.min_slot] = 1'b0;
                            cdid_next = c_sum.min_id;
                        end
                    end
                end
            end
            else
            begin
                status_next = ST_PENDING;
            end
        end
    end

    // hold state, scan index, valid bits, the last popped id and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            scan_idx_reg        <= '0;
            pending_valid_reg   <= '0;
            completed_valid_reg <= '0;
            last_completed_reg  <= '0;
            rsp_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cmd_take)
            begin
                scan_idx_reg <= '0;
            end
            else if (scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
            end

            if (commit)
            begin
                pending_valid_reg   <= pending_valid_next;
                completed_valid_reg <= completed_valid_next;
                last_completed_reg  <= last_completed_next;
                rsp_valid_reg       <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // capture the command word, the matching entry and the result fields
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_reg <= command;
            fid_reg <= frame_id;
            idx_reg <= fragment_index;
            cnt_reg <= fragment_count;
        end
        if (p_hit)
        begin
            match_count_reg <= pending_count_reg[scan_idx_reg];
            match_map_reg   <= pending_map_reg[scan_idx_reg];
        end
        if (commit)
        begin
            status_reg <= status_next;
            rid_reg    <= rid_next;
            gap_reg    <= gap_next;
            pdrop_reg  <= pdrop_next;
            pdid_reg   <= pdid_next;
            cdrop_reg  <= cdrop_next;
            cdid_reg   <= cdid_next;
        end
    end

    // write table entries
    always_ff @(posedge clk)
    begin
        if (commit && p_wr_en)
        begin
            pending_map_reg[p_wr_slot] <= p_wr_map;
            if (p_wr_new)
            begin
                pending_id_reg[p_wr_slot]    <= fid_reg;
                pending_count_reg[p_wr_slot] <= cnt_reg;
            end
        end
        if (commit && c_wr_en)
        begin
            completed_id_reg[c_wr_slot] <= fid_reg;
        end
    end

    assign rsp_valid            = rsp_valid_reg;
    assign status               = status_reg;
    assign result_frame_id      = rid_reg;
    assign gap_detected         = gap_reg;
    assign pending_dropped      = pdrop_reg;
    assign pending_dropped_id   = pdid_reg;
    assign completed_dropped    = cdrop_reg;
    assign completed_dropped_id = cdid_reg;

    // between commands the pending table stays within its limit
    a_pend_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && PENDING_LIMIT < SLOTS)
        |-> ($countones(pending_valid_reg) <= PENDING_LIMIT))
        else $error("pending table above its limit");

    // between commands the completed queue stays within its limit
    a_comp_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && COMPLETED_LIMIT < SLOTS)
        |-> ($countones(completed_valid_reg) <= COMPLETED_LIMIT))
        else $error("completed queue above its limit");

    // a popped id shown on the response is the last completed id
    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg == ST_POPPED)
        |-> (last_completed_reg == rid_reg))
        else $error("popped id and last completed id disagree");

    // a queued id that matches the command's frame id lies above the last popped id
    a_queue_above_last: assert property (@(posedge clk) disable iff (!rst_n)
        c_hit |-> (fid_reg > last_completed_reg))
        else $error("completed queue holds an id at or below the last popped id");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the fragment reassembly tracker
// Feeds add and pop words through the valid/stall command channel, predicts
// every response word with a local copy of the pending table, the completed
// queue and the last popped id, and compares each response field by field.
// A short directed opening is followed by interleaved random frames mixed
// with pops and malformed or stale fragments; both sides idle at random.
// ----------------------------------------------------------------------------
module tb;

    import frt_pkg::*;

    localparam int PEND_LIMIT    = 15;
    localparam int DONE_LIMIT    = 15;
    localparam int MAX_FRAGS     = 32;
    localparam int RANDOM_WORDS  = 1625;
    localparam int CALM_WORDS    = 120;
    localparam int TAIL_CYCLES   = 40;
    localparam int MAX_REPORTS   = 100;
    localparam int TIMEOUT_NS    = 2_000_000;

    // one command word, plus a flag that holds it back until all responses are in
    typedef struct packed {
        logic              drain;
        logic              command;
        logic [ID_W-1:0]   frame_id;
        logic [IDX_W-1:0]  fragment_index;
        logic [FCNT_W-1:0] fragment_count;
    } frag_word_t;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [ID_W-1:0] frame_id;
        logic            gap;
        logic            pdrop;
        logic [ID_W-1:0] pdid;
        logic            cdrop;
        logic [ID_W-1:0] cdid;
    } tracker_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              cmd_valid = 1'b0;
    logic              cmd_stall;
    frag_word_t        cur = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   result_frame_id;
    logic              gap_detected;
    logic              pending_dropped;
    logic [ID_W-1:0]   pending_dropped_id;
    logic              completed_dropped;
    logic [ID_W-1:0]   completed_dropped_id;

    // predicted tracker state
    logic [SLOTS-1:0]             pend_v = '0;
    logic [SLOTS-1:0][ID_W-1:0]   pend_id;
    logic [SLOTS-1:0][FCNT_W-1:0] pend_cnt;
    logic [SLOTS-1:0][63:0]       pend_map;
    logic [SLOTS-1:0]             done_v = '0;
    logic [SLOTS-1:0][ID_W-1:0]   done_id;
    logic [ID_W-1:0]              last_done = '0;

    frag_word_t      word_q[$];
    tracker_result_t result_q[$];
    tracker_result_t want;
    logic            drain_next = 1'b0;
    logic            calm = 1'b0;
    int              gap_left = 0;
    int              stall_left = 0;
    int              words_accepted = 0;
    int              results_seen = 0;
    int              errors = 0;
    int              status_seen [8];
    int              gaps_seen = 0;
    int              pend_evictions = 0;
    int              done_evictions = 0;

    fragment_reassembly_tracker #(
        .PENDING_LIMIT   (PEND_LIMIT),
        .COMPLETED_LIMIT (DONE_LIMIT),
        .MAX_FRAGMENTS   (MAX_FRAGS)
    ) uut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd_valid            (cmd_valid),
        .cmd_stall            (cmd_stall),
        .command              (cur.command),
        .frame_id             (cur.frame_id),
        .fragment_index       (cur.fragment_index),
        .fragment_count       (cur.fragment_count),
        .rsp_valid            (rsp_valid),
        .rsp_stall            (rsp_stall),
        .status               (status),
        .result_frame_id      (result_frame_id),
        .gap_detected         (gap_detected),
        .pending_dropped      (pending_dropped),
        .pending_dropped_id   (pending_dropped_id),
        .completed_dropped    (completed_dropped),
        .completed_dropped_id (completed_dropped_id)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hold reset at the start, then release it
    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // hard stop if the design hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout: responses stopped arriving");
        $display("DONE: errors detected");
        $finish;
    end

    // slot with the smallest valid id, -1 when the table is empty
    function automatic int lowest_id_slot(input logic [SLOTS-1:0] v,
                                          input logic [SLOTS-1:0][ID_W-1:0] ids);
        int best;
        int i;
        best = -1;
        for (i = 0; i < SLOTS; i++)
            if (v[i] && (best < 0 || ids[i] < ids[best]))
                best = i;
        return best;
    endfunction

    function automatic int first_free_slot(input logic [SLOTS-1:0] v);
        int i;
        for (i = 0; i < SLOTS; i++)
            if (!v[i])
                return i;
        return -1;
    endfunction

    // apply one accepted word to the predicted state and return its response
    function automatic tracker_result_t track_word(input frag_word_t w);
        tracker_result_t r;
        int              slot;
        int              c;
        int              s;
        int              i;
        logic [63:0]     bit_m;
        logic [63:0]     full_m;
        logic            queued;
        r = '0;
        r.status = ST_PENDING;
        if (w.command == CMD_POP)
        begin
            s = lowest_id_slot(done_v, done_id);
            if (s < 0)
                r.status = ST_EMPTY;
            else
            begin
                r.status   = ST_POPPED;
                r.frame_id = done_id[s];
                r.gap      = (done_id[s] != last_done + 32'd1);
                done_v[s]  = 1'b0;
                last_done  = done_id[s];
            end
        end
        else if (w.frame_id <= last_done)
            r.status = ST_ALREADY;
        else
        begin
            // find the frame, first matching slot wins
            slot = -1;
            for (i = SLOTS - 1; i >= 0; i--)
                if (pend_v[i] && pend_id[i] == w.frame_id)
                    slot = i;
            if (slot < 0)
            begin
                if (w.fragment_count == '0 || int'(w.fragment_count) > MAX_FRAGS ||
                    {1'b0, w.fragment_index} >= w.fragment_count)
                    r.status = ST_BADINDEX;
                else
                begin
                    // open a new entry, evicting the smallest id if the table is full
                    slot = first_free_slot(pend_v);
                    if (slot < 0)
                    begin
                        slot    = lowest_id_slot(pend_v, pend_id);
                        r.pdrop = 1'b1;
                        r.pdid  = pend_id[slot];
                    end
                    pend_v[slot]   = 1'b1;
                    pend_id[slot]  = w.frame_id;
                    pend_cnt[slot] = w.fragment_count;
                    pend_map[slot] = '0;
                end
            end
            else if ({1'b0, w.fragment_index} >= pend_cnt[slot])
                r.status = ST_BADINDEX;

            if (r.status != ST_BADINDEX)
            begin
                bit_m  = 64'd1 << w.fragment_index;
                full_m = (64'd1 << pend_cnt[slot]) - 64'd1;
                if ((pend_map[slot] & bit_m) != '0)
                    r.status = ST_ALREADY;
                else
                begin
                    pend_map[slot] = pend_map[slot] | bit_m;
                    if ((pend_map[slot] & full_m) == full_m)
                    begin
                        r.status   = ST_COMPLETED;
                        r.frame_id = w.frame_id;
                        queued = 1'b0;
                        for (i = 0; i < SLOTS; i++)
                            if (done_v[i] && done_id[i] == w.frame_id)
                                queued = 1'b1;
                        if (!queued)
                        begin
                            c = first_free_slot(done_v);
                            if (c < 0)
                            begin
                                c       = lowest_id_slot(done_v, done_id);
                                r.cdrop = 1'b1;
                                r.cdid  = done_id[c];
                            end
                            done_v[c]  = 1'b1;
                            done_id[c] = w.frame_id;
                        end
                    end
                    // trim both tables back to their limits
                    while ($countones(pend_v) > PEND_LIMIT)
                    begin
                        s         = lowest_id_slot(pend_v, pend_id);
                        r.pdrop   = 1'b1;
                        r.pdid    = pend_id[s];
                        pend_v[s] = 1'b0;
                    end
                    if (r.status == ST_COMPLETED)
                        while ($countones(done_v) > DONE_LIMIT)
                        begin
                            s         = lowest_id_slot(done_v, done_id);
                            r.cdrop   = 1'b1;
                            r.cdid    = done_id[s];
                            done_v[s] = 1'b0;
                        end
                end
            end
        end
        return r;
    endfunction

    task automatic queue_word(input logic cmd, input logic [ID_W-1:0] fid,
                              input logic [IDX_W-1:0] idx, input logic [FCNT_W-1:0] cnt);
        frag_word_t w;
        w.drain          = drain_next;
        w.command        = cmd;
        w.frame_id       = fid;
        w.fragment_index = idx;
        w.fragment_count = cnt;
        word_q.push_back(w);
        drain_next = 1'b0;
    endtask

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // driver: present queued words, idle in short bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            gap_left  <= 0;
        end
        else
        begin
            calm <= (word_q.size() < CALM_WORDS);
            if (cmd_valid && !cmd_stall)
            begin
                result_q.push_back(track_word(cur));
                words_accepted++;
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left  <= gap_left - 1;
                    cmd_valid <= 1'b0;
                end
                else if (word_q.size() == 0 || (word_q[0].drain && result_q.size() != 0))
                    cmd_valid <= 1'b0;
                else if (!calm && ((words_accepted / 150) % 3 != 1) &&
                         $urandom_range(99) < 20)
                begin
                    gap_left  <= $urandom_range(2);
                    cmd_valid <= 1'b0;
                end
                else
                begin
                    cur       <= word_q.pop_front();
                    cmd_valid <= 1'b1;
                end
            end
        end
    end

    // monitor: check each response word, stall in short bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                results_seen++;
                if (result_q.size() == 0)
                    report_mismatch($sformatf("response word with nothing expected, status %0d",
                                              status));
                else
                begin
                    want = result_q.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  status, want.status));
                    if (result_frame_id !== want.frame_id)
                        report_mismatch($sformatf("result_frame_id got %0h want %0h",
                                                  result_frame_id, want.frame_id));
                    if (gap_detected !== want.gap)
                        report_mismatch($sformatf("gap_detected got %0b want %0b",
                                                  gap_detected, want.gap));
                    if (pending_dropped !== want.pdrop)
                        report_mismatch($sformatf("pending_dropped got %0b want %0b",
                                                  pending_dropped, want.pdrop));
                    if (pending_dropped_id !== want.pdid)
                        report_mismatch($sformatf("pending_dropped_id got %0h want %0h",
                                                  pending_dropped_id, want.pdid));
                    if (completed_dropped !== want.cdrop)
                        report_mismatch($sformatf("completed_dropped got %0b want %0b",
                                                  completed_dropped, want.cdrop));
                    if (completed_dropped_id !== want.cdid)
                        report_mismatch($sformatf("completed_dropped_id got %0h want %0h",
                                                  completed_dropped_id, want.cdid));
                    status_seen[want.status]++;
                    if (want.gap)
                        gaps_seen++;
                    if (want.pdrop)
                        pend_evictions++;
                    if (want.cdrop)
                        done_evictions++;
                end
            end
            if (stall_left > 0)
            begin
                rsp_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (!calm && ((results_seen / 150) % 3 != 2) && $urandom_range(99) < 25)
            begin
                rsp_stall  <= 1'b1;
                stall_left <= $urandom_range(2);
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // stimulus and end of run
    initial
    begin : stimulus
        logic [3:0][ID_W-1:0]   open_fid;
        logic [3:0][FCNT_W-1:0] open_cnt;
        logic [3:0][31:0]       open_left;
        logic [3:0]             open_on;
        logic [3:0]             open_started;
        logic [ID_W-1:0]        next_fid;
        int                     n;
        int                     r;
        int                     k;
        int                     j;
        int                     b;
        int                     cnt;
        int                     n_open;
        int                     pop_pct;

        open_on      = '0;
        open_started = '0;
        open_fid     = '0;
        open_cnt     = '0;
        open_left    = '0;
        for (n = 0; n < 8; n++)
            status_seen[n] = 0;

        // directed opening: empty pop, stale, malformed counts, index limits,
        // repeated fragments, completion, in-order pops and a gap
        queue_word(CMD_POP, '0, '0, '0);
        queue_word(CMD_ADD, 32'd0, 5'd0, 6'd1);
        queue_word(CMD_ADD, 32'd5, 5'd3, 6'd0);
        queue_word(CMD_ADD, 32'd5, 5'd0, 6'd33);
        queue_word(CMD_ADD, 32'h8000_0000, 5'd0, 6'd63);
        queue_word(CMD_ADD, 32'hFFFF_FFFF, 5'd2, 6'd2);
        queue_word(CMD_ADD, 32'd5, 5'd31, 6'd32);
        queue_word(CMD_ADD, 32'd5, 5'd31, 6'd7);
        queue_word(CMD_ADD, 32'd5, 5'd3, 6'd7);
        queue_word(CMD_ADD, 32'd1, 5'd0, 6'd1);
        queue_word(CMD_ADD, 32'd1, 5'd0, 6'd1);
        queue_word(CMD_ADD, 32'd3, 5'd1, 6'd2);
        queue_word(CMD_ADD, 32'd3, 5'd5, 6'd2);
        queue_word(CMD_ADD, 32'd3, 5'd0, 6'd2);
        queue_word(CMD_ADD, 32'd2, 5'd0, 6'd1);
        queue_word(CMD_POP, '1, '1, '1);
        queue_word(CMD_POP, '0, '0, '0);
        queue_word(CMD_POP, '0, '0, '0);
        queue_word(CMD_ADD, 32'd7, 5'd0, 6'd1);
        queue_word(CMD_POP, '0, '0, '0);
        queue_word(CMD_POP, '0, '0, '0);
        queue_word(CMD_ADD, 32'd2, 5'd0, 6'd1);
        queue_word(CMD_ADD, 32'd5, 5'd4, 6'd32);

        // random part: interleaved frames, pops at a varying rate, and noise
        next_fid = 32'd20;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == 300 || n == 900)
                drain_next = 1'b1;
            case ((n / 200) % 4)
                0:       pop_pct = 20;
                1:       pop_pct = 4;
                2:       pop_pct = 45;
                default: pop_pct = 12;
            endcase
            r = $urandom_range(99);
            if (r < pop_pct)
                queue_word(CMD_POP, $urandom, IDX_W'($urandom), FCNT_W'($urandom));
            else if (r < pop_pct + 10)
            begin
                case ($urandom_range(3))
                    0:
                        queue_word(CMD_ADD, $urandom, IDX_W'($urandom),
                                   $urandom_range(1) ? 6'd0 : FCNT_W'($urandom_range(33, 63)));
                    1:
                    begin
                        k = $urandom_range(1, 31);
                        queue_word(CMD_ADD, $urandom, IDX_W'($urandom_range(k, 31)),
                                   FCNT_W'(k));
                    end
                    2:
                        queue_word(CMD_ADD,
                                   (next_fid > 32'd40) ? next_fid - $urandom_range(1, 40) : '0,
                                   IDX_W'($urandom_range(1)), FCNT_W'($urandom_range(1, 2)));
                    default:
                        queue_word(CMD_ADD, next_fid + $urandom_range(0, 30),
                                   IDX_W'($urandom_range(7)), FCNT_W'($urandom_range(1, 8)));
                endcase
            end
            else
            begin
                // open another frame now and then, up to four in flight
                n_open = 0;
                for (j = 0; j < 4; j++)
                    n_open += int'(open_on[j]);
                if (n_open == 0 || (n_open < 4 && $urandom_range(3) == 0))
                begin
                    j = 0;
                    while (open_on[j])
                        j++;
                    k = $urandom_range(99);
                    cnt = (k < 80) ? $urandom_range(1, 4) :
                          (k < 95) ? $urandom_range(5, 12) : $urandom_range(13, 32);
                    open_on[j]      = 1'b1;
                    open_started[j] = 1'b0;
                    open_fid[j]     = next_fid;
                    open_cnt[j]     = FCNT_W'(cnt);
                    open_left[j]    = (cnt == 32) ? '1 : (32'd1 << cnt) - 32'd1;
                    next_fid        = next_fid + (($urandom_range(9) == 0) ? 32'd2 : 32'd1);
                end
                // pick a frame and one of its missing fragments
                j = $urandom_range(3);
                while (!open_on[j])
                    j = (j + 1) % 4;
                b = $urandom_range(31);
                while (!open_left[j][b])
                    b = (b + 1) % 32;
                k = $urandom_range(99);
                if (k < 4 && open_cnt[j] < 6'd32)
                    queue_word(CMD_ADD, open_fid[j],
                               IDX_W'($urandom_range(open_cnt[j], 31)), open_cnt[j]);
                else
                begin
                    // later fragments sometimes carry a different count
                    queue_word(CMD_ADD, open_fid[j], IDX_W'(b),
                               (!open_started[j] || k >= 14) ? open_cnt[j] :
                               FCNT_W'($urandom_range(1, 63)));
                    open_started[j] = 1'b1;
                    // leave the bit set now and then so the fragment repeats
                    if (k >= 8)
                        open_left[j][b] = 1'b0;
                    if (open_left[j] == '0)
                        open_on[j] = 1'b0;
                end
            end
        end

        // drain, then let the pipeline settle
        wait (rst_n === 1'b1);
        while (word_q.size() != 0 || cmd_valid || result_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d words: %0d pending, %0d stale or repeated, %0d bad index,",
                 words_accepted, status_seen[ST_PENDING], status_seen[ST_ALREADY],
                 status_seen[ST_BADINDEX]);
        $display("%0d completed, %0d popped (%0d with a gap), %0d empty pops, %0d/%0d evictions",
                 status_seen[ST_COMPLETED], status_seen[ST_POPPED], gaps_seen,
                 status_seen[ST_EMPTY], pend_evictions, done_evictions);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
